### rtl/sws_pkg.sv
// Shared constants, types and tables for the windowed sample statistics block.
package sws_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = 32 + CNT_W;
    localparam int DSUM_W       = 33 + CNT_W;
    localparam int PADDR_W      = 3;

    localparam logic [31:0] TICK_RATE_RST = 32'd1000000;

    // Register index in the configuration map
    localparam logic REG_TICK_RATE = 1'b0;

    // Action codes
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Statistic select codes
    localparam logic [3:0] STAT_MAX       = 4'd0;
    localparam logic [3:0] STAT_MIN       = 4'd1;
    localparam logic [3:0] STAT_SUM       = 4'd2;
    localparam logic [3:0] STAT_MEAN      = 4'd3;
    localparam logic [3:0] STAT_SUMDUR    = 4'd4;
    localparam logic [3:0] STAT_MEANDUR   = 4'd5;
    localparam logic [3:0] STAT_MINDUR    = 4'd6;
    localparam logic [3:0] STAT_MEANRATE  = 4'd7;
    localparam logic [3:0] STAT_MAXRATE   = 4'd8;
    localparam logic [3:0] STAT_MINRATE   = 4'd9;
    localparam logic [3:0] STAT_PREV      = 4'd10;
    localparam logic [3:0] STAT_PREVRATE  = 4'd11;
    localparam logic [3:0] STAT_PREVBEGIN = 4'd12;
    localparam logic [3:0] STAT_PREVEND   = 4'd13;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    // One window entry
    typedef struct packed {
        logic signed [31:0] value;
        logic        [31:0] seg_begin;
        logic        [31:0] seg_end;
        logic signed [32:0] seg_dur;
    } entry_t;

    // Request to the scaled divider: a * b / d
    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic        [31:0] b;
        logic signed [63:0] d;
    } div_req_t;

    // Entry age folded into the window
    typedef logic [IDX_W-1:0] age_mod_t [256];

    function automatic age_mod_t make_age_mod();
        age_mod_t t;
        for (int k = 0; k < 256; k++) begin
            t[k] = IDX_W'(k % WINDOW_DEPTH);
        end
        return t;
    endfunction

    localparam age_mod_t AGE_MOD = make_age_mod();

endpackage

### rtl/windowed_sample_statistics_core.sv
// Sliding-window sample statistics: sequencer over the entry memory and divider.
//
// One transaction at a time enters the block. An add writes the closing slot and
// then the opening slot, a segment start rewrites the open slot and a clear writes
// nothing, each then loading the output register. A query walks the window entry
// by entry through the single read port of the entry memory; each division runs
// in the shared divider (two partial products, then one quotient bit a cycle).
// Max and min rate divide once per entry with a positive duration and at most
// once more for priming; means take one walk and one division, previous-entry
// queries one read, previous rate one division.
// A finished result waits in the output register while the next transaction is
// taken. Clear empties the window at once.
module windowed_sample_statistics_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sws_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic signed [31:0]            sample_value,
    input  logic [31:0]                   sample_time,
    input  logic [3:0]                    stat_select,
    input  logic [7:0]                    entry_age,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [63:0]            result_value,
    output logic [8:0]                    filled_count
);
    import sws_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_ADD_B = 14'b00000000000010,
        S_ADD_C = 14'b00000000000100,
        S_BEG_B = 14'b00000000001000,
        S_PR0   = 14'b00000000010000,
        S_PR1   = 14'b00000000100000,
        S_PRDIV = 14'b00000001000000,
        S_WALK  = 14'b00000010000000,
        S_WDAT  = 14'b00000100000000,
        S_WDIV  = 14'b00001000000000,
        S_FIN   = 14'b00010000000000,
        S_FDIV  = 14'b00100000000000,
        S_PREV  = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_W  = (IDX_W + 1)'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(WINDOW_DEPTH);

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          cur_reg, cur_next;
    logic [IDX_W-1:0]          nxt_reg, nxt_next;
    logic signed [31:0]        last_reg, last_next;
    logic signed [31:0]        val_reg, val_next;
    logic [31:0]               t_reg, t_next;
    logic [3:0]                sel_reg, sel_next;
    logic [IDX_W-1:0]          prev_reg, prev_next;
    logic [CNT_W-1:0]          i_reg, i_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]   vsum_reg, vsum_next;
    logic signed [DSUM_W-1:0]  dsum_reg, dsum_next;
    logic signed [31:0]        mx_reg, mx_next;
    logic signed [31:0]        mn_reg, mn_next;
    logic signed [32:0]        dmin_reg, dmin_next;
    logic                      have_d_reg, have_d_next;
    logic signed [63:0]        rmax_reg, rmax_next;
    logic signed [63:0]        rmin_reg, rmin_next;
    logic signed [63:0]        res_reg, res_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [63:0]        result_reg, result_next;
    logic [8:0]                filled_reg, filled_next;

    logic [31:0]               tick_rate;
    entry_t                    rd;
    entry_t                    ram_wdata;
    logic                      ram_we;
    logic                      ram_clr;
    logic [IDX_W-1:0]          ram_waddr;
    logic [IDX_W-1:0]          ram_raddr;
    div_req_t                  div_req;
    logic                      div_done;
    logic signed [63:0]        div_q;

    logic                      accept;
    logic [IDX_W:0]            age_back;
    logic [IDX_W-1:0]          age_slot;
    logic [IDX_W-1:0]          nxt_inc;
    logic                      rate_sel;
    logic                      prev_sel;
    logic signed [32:0]        add_dur;

    sws_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .tick_rate (tick_rate)
    );

    sws_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (ram_clr),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd)
    );

    sws_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .q     (div_q)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid & ~in_stall;

    // Slot a given age back from the newest entry
    assign age_back = {1'b0, cur_reg} + DEPTH_W - {1'b0, AGE_MOD[entry_age]};
    assign age_slot = (age_back >= DEPTH_W) ? IDX_W'(age_back - DEPTH_W) : age_back[IDX_W-1:0];
    assign nxt_inc  = (nxt_reg == LAST_IDX) ? '0 : nxt_reg + IDX_W'(1);
    assign rate_sel = (sel_reg == STAT_MAXRATE) || (sel_reg == STAT_MINRATE);
    assign prev_sel = (stat_select == STAT_PREV) || (stat_select == STAT_PREVRATE) ||
                      (stat_select == STAT_PREVBEGIN) || (stat_select == STAT_PREVEND);
    assign add_dur  = $signed({1'b0, t_reg}) - $signed({1'b0, rd.seg_begin});

    // Sequence each transaction over the entry memory
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        last_next      = last_reg;
        val_next       = val_reg;
        t_next         = t_reg;
        sel_next       = sel_reg;
        prev_next      = prev_reg;
        i_next         = i_reg;
        cnt_next       = cnt_reg;
        vsum_next      = vsum_reg;
        dsum_next      = dsum_reg;
        mx_next        = mx_reg;
        mn_next        = mn_reg;
        dmin_next      = dmin_reg;
        have_d_next    = have_d_reg;
        rmax_next      = rmax_reg;
        rmin_next      = rmin_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        filled_next    = filled_reg;
        ram_we         = 1'b0;
        ram_clr        = 1'b0;
        ram_waddr      = nxt_reg;
        ram_wdata      = rd;
        ram_raddr      = nxt_reg;
        div_req        = '{start: 1'b0, a: 64'sd0, b: 32'd1, d: 64'sd1};

        // Drop the output transaction once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next  = sample_value;
                    t_next    = sample_time;
                    sel_next  = stat_select;
                    prev_next = age_slot;
                    res_next  = 64'sd0;
                    unique case (action)
                        ACT_ADD:
                        begin
                            state_next = S_ADD_B;
                        end
                        ACT_START:
                        begin
                            state_next = S_BEG_B;
                        end
                        ACT_QUERY:
                        begin
                            i_next      = '0;
                            cnt_next    = '0;
                            vsum_next   = '0;
                            dsum_next   = '0;
                            mx_next     = last_reg;
                            mn_next     = last_reg;
                            dmin_next   = '0;
                            have_d_next = 1'b0;
                            rmax_next   = 64'sd0;
                            rmin_next   = 64'sd0;
                            if (prev_sel)
                            begin
                                ram_raddr  = age_slot;
                                state_next = S_PREV;
                            end
                            else if ((stat_select == STAT_MAXRATE) ||
                                     (stat_select == STAT_MINRATE))
                            begin
                                ram_raddr  = '0;
                                state_next = S_PR0;
                            end
                            else if (stat_select > STAT_PREVEND)
                            begin
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            ram_clr    = 1'b1;
                            count_next = '0;
                            cur_next   = LAST_IDX;
                            nxt_next   = '0;
                            last_next  = 32'sd0;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Close the filling slot, then open the one after it
            S_ADD_B:
            begin
                ram_we     = 1'b1;
                ram_waddr  = nxt_reg;
                ram_wdata  = '{value: val_reg, seg_begin: rd.seg_begin, seg_end: t_reg,
                               seg_dur: add_dur};
                ram_raddr  = nxt_inc;
                cur_next   = nxt_reg;
                nxt_next   = nxt_inc;
                last_next  = val_reg;
                if (count_reg < DEPTH_C)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_ADD_C;
            end
            S_ADD_C:
            begin
                ram_we     = 1'b1;
                ram_waddr  = nxt_reg;
                ram_wdata  = '{value: rd.value, seg_begin: t_reg, seg_end: t_reg,
                               seg_dur: 33'sd0};
                state_next = S_EMIT;
            end

            // Move the begin time of the open segment
            S_BEG_B:
            begin
                ram_we          = 1'b1;
                ram_waddr       = nxt_reg;
                ram_wdata       = rd;
                ram_wdata.seg_begin = t_reg;
                state_next      = S_EMIT;
            end

            // Prime the rate extremes from slot 0, else slot 1
            S_PR0:
            begin
                if ((nxt_reg != '0) && (rd.seg_dur != 33'sd0))
                begin
                    div_req    = '{start: 1'b1, a: 64'(rd.value), b: tick_rate,
                                   d: 64'(rd.seg_dur)};
                    state_next = S_PRDIV;
                end
                else
                begin
                    ram_raddr  = IDX_W'(1);
                    state_next = S_PR1;
                end
            end
            S_PR1:
            begin
                if ((count_reg != '0) && (rd.seg_dur != 33'sd0))
                begin
                    div_req    = '{start: 1'b1, a: 64'(rd.value), b: tick_rate,
                                   d: 64'(rd.seg_dur)};
                    state_next = S_PRDIV;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_PRDIV:
            begin
                if (div_done)
                begin
                    rmax_next  = div_q;
                    rmin_next  = div_q;
                    state_next = S_WALK;
                end
            end

            // Walk the valid entries, skipping the filling slot
            S_WALK:
            begin
                ram_raddr = i_reg[IDX_W-1:0];
                if (i_reg == count_reg)
                begin
                    state_next = S_FIN;
                end
                else if (i_reg == CNT_W'(nxt_reg))
                begin
                    i_next = i_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_WDAT;
                end
            end
            S_WDAT:
            begin
                cnt_next  = cnt_reg + CNT_W'(1);
                vsum_next = vsum_reg + SUM_W'(rd.value);
                dsum_next = dsum_reg + DSUM_W'(rd.seg_dur);
                if (rd.value > mx_reg)
                begin
                    mx_next = rd.value;
                end
                if (rd.value < mn_reg)
                begin
                    mn_next = rd.value;
                end
                if (!have_d_reg || (rd.seg_dur < dmin_reg))
                begin
                    dmin_next   = rd.seg_dur;
                    have_d_next = 1'b1;
                end
                if (rate_sel && (rd.seg_dur > 33'sd0))
                begin
                    div_req    = '{start: 1'b1, a: 64'(rd.value), b: tick_rate,
                                   d: 64'(rd.seg_dur)};
                    state_next = S_WDIV;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_WALK;
                end
            end
            S_WDIV:
            begin
                if (div_done)
                begin
                    if (div_q > rmax_reg)
                    begin
                        rmax_next = div_q;
                    end
                    if (div_q < rmin_reg)
                    begin
                        rmin_next = div_q;
                    end
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_WALK;
                end
            end

            // Pick the statistic, dividing once where needed
            S_FIN:
            begin
                state_next = S_EMIT;
                case (sel_reg)
                    STAT_MAX:     res_next = 64'(mx_reg);
                    STAT_MIN:     res_next = 64'(mn_reg);
                    STAT_SUM:     res_next = 64'(vsum_reg);
                    STAT_SUMDUR:  res_next = 64'(dsum_reg);
                    STAT_MINDUR:  res_next = 64'(dmin_reg);
                    STAT_MAXRATE: res_next = rmax_reg;
                    STAT_MINRATE: res_next = rmin_reg;
                    STAT_MEAN:
                    begin
                        res_next = 64'sd0;
                        if (cnt_reg != '0)
                        begin
                            div_req    = '{start: 1'b1, a: 64'(vsum_reg), b: 32'd1,
                                           d: $signed(64'(cnt_reg))};
                            state_next = S_FDIV;
                        end
                    end
                    STAT_MEANDUR:
                    begin
                        res_next = 64'sd0;
                        if (cnt_reg != '0)
                        begin
                            div_req    = '{start: 1'b1, a: 64'(dsum_reg), b: 32'd1,
                                           d: $signed(64'(cnt_reg))};
                            state_next = S_FDIV;
                        end
                    end
                    STAT_MEANRATE:
                    begin
                        res_next = 64'sd0;
                        if (dsum_reg > DSUM_W'(0))
                        begin
                            div_req    = '{start: 1'b1, a: 64'(vsum_reg), b: tick_rate,
                                           d: 64'(dsum_reg)};
                            state_next = S_FDIV;
                        end
                    end
                    default:      res_next = 64'sd0;
                endcase
            end
            S_FDIV:
            begin
                if (div_done)
                begin
                    res_next   = div_q;
                    state_next = S_EMIT;
                end
            end

            // Read back one earlier entry
            S_PREV:
            begin
                state_next = S_EMIT;
                res_next   = 64'sd0;
                if (prev_reg != nxt_reg)
                begin
                    case (sel_reg)
                        STAT_PREV:      res_next = 64'(rd.value);
                        STAT_PREVBEGIN: res_next = $signed({32'd0, rd.seg_begin});
                        STAT_PREVEND:   res_next = $signed({32'd0, rd.seg_end});
                        STAT_PREVRATE:
                        begin
                            if (rd.seg_dur != 33'sd0)
                            begin
                                div_req    = '{start: 1'b1, a: 64'(rd.value), b: tick_rate,
                                               d: 64'(rd.seg_dur)};
                                state_next = S_FDIV;
                            end
                        end
                        default:        res_next = 64'sd0;
                    endcase
                end
            end

            // Load the output register when it is free
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    result_next    = res_reg;
                    filled_next    = 9'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_reg       <= LAST_IDX;
            nxt_reg       <= '0;
            last_reg      <= 32'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            nxt_reg       <= nxt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the working set and output payload
    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        t_reg      <= t_next;
        sel_reg    <= sel_next;
        prev_reg   <= prev_next;
        i_reg      <= i_next;
        cnt_reg    <= cnt_next;
        vsum_reg   <= vsum_next;
        dsum_reg   <= dsum_next;
        mx_reg     <= mx_next;
        mn_reg     <= mn_next;
        dmin_reg   <= dmin_next;
        have_d_reg <= have_d_next;
        rmax_reg   <= rmax_next;
        rmin_reg   <= rmin_next;
        res_reg    <= res_next;
        result_reg <= result_next;
        filled_reg <= filled_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign filled_count = filled_reg;

endmodule

### rtl/sws_ram.sv
// Window entry memory with per-entry valid bits and a registered read.
module sws_ram (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clr,
    input  logic                          we,
    input  logic [sws_pkg::IDX_W-1:0]     waddr,
    input  sws_pkg::entry_t               wdata,
    input  logic [sws_pkg::IDX_W-1:0]     raddr,
    output sws_pkg::entry_t               rdata
);
    import sws_pkg::*;

    entry_t                  store_reg [WINDOW_DEPTH];
    entry_t                  rdata_reg;
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic                    rvalid_reg;

    // Write and read the entry array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    // Track written entries; clear empties the window at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= valid_reg[raddr];
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    // Unwritten entries read as zero
    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

### rtl/sws_div.sv
// Iterative signed a * b / d with truncation and 64-bit saturation.
module sws_div (
    input  logic                clk,
    input  logic                rst_n,
    input  sws_pkg::div_req_t   req,
    output logic                done,
    output logic signed [63:0]  q
);
    import sws_pkg::*;

    typedef enum logic [5:0] {
        DV_IDLE = 6'b000001,
        DV_MUL0 = 6'b000010,
        DV_MUL1 = 6'b000100,
        DV_CHK  = 6'b001000,
        DV_ITER = 6'b010000,
        DV_FIN  = 6'b100000
    } dv_state_t;

    dv_state_t          state_reg, state_next;
    logic [63:0]        ua_reg, ua_next;
    logic [63:0]        ud_reg, ud_next;
    logic [31:0]        b_reg, b_next;
    logic               neg_reg, neg_next;
    logic [63:0]        p0_reg, p0_next;
    logic [63:0]        p1_reg, p1_next;
    logic [63:0]        lo_reg, lo_next;
    logic [63:0]        r_reg, r_next;
    logic [63:0]        qacc_reg, qacc_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic signed [63:0] q_reg, q_next;

    logic [95:0]        prod;
    logic [63:0]        rs;
    logic [63:0]        diff;
    logic               take;

    assign prod = {32'd0, p0_reg} + {p1_reg, 32'd0};
    assign rs   = {r_reg[62:0], lo_reg[63]};
    assign diff = rs - ud_reg;
    assign take = r_reg[63] | (rs >= ud_reg);

    // Sequence: magnitudes, two partial products, overflow check, one quotient bit a cycle
    always_comb
    begin
        state_next = state_reg;
        ua_next    = ua_reg;
        ud_next    = ud_reg;
        b_next     = b_reg;
        neg_next   = neg_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        lo_next    = lo_reg;
        r_next     = r_reg;
        qacc_next  = qacc_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        q_next     = q_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (req.start)
                begin
                    ua_next    = req.a[63] ? (64'd0 - 64'(req.a)) : 64'(req.a);
                    ud_next    = req.d[63] ? (64'd0 - 64'(req.d)) : 64'(req.d);
                    neg_next   = req.a[63] ^ req.d[63];
                    b_next     = req.b;
                    state_next = DV_MUL0;
                end
            end
            DV_MUL0:
            begin
                p0_next    = ua_reg[31:0] * b_reg;
                state_next = DV_MUL1;
            end
            DV_MUL1:
            begin
                p1_next    = ua_reg[63:32] * b_reg;
                state_next = DV_CHK;
            end
            DV_CHK:
            begin
                if ({32'd0, prod[95:64]} >= ud_reg)
                begin
                    q_next     = neg_reg ? S64_MIN : S64_MAX;
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end
                else
                begin
                    r_next     = {32'd0, prod[95:64]};
                    lo_next    = prod[63:0];
                    qacc_next  = '0;
                    cnt_next   = '0;
                    state_next = DV_ITER;
                end
            end
            DV_ITER:
            begin
                r_next    = take ? diff : rs;
                qacc_next = {qacc_reg[62:0], take};
                lo_next   = {lo_reg[62:0], 1'b0};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = DV_FIN;
                end
            end
            DV_FIN:
            begin
                if (neg_reg)
                begin
                    q_next = qacc_reg[63] ? S64_MIN : -$signed(qacc_reg);
                end
                else
                begin
                    q_next = qacc_reg[63] ? S64_MAX : $signed(qacc_reg);
                end
                done_next  = 1'b1;
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        ua_reg   <= ua_next;
        ud_reg   <= ud_next;
        b_reg    <= b_next;
        neg_reg  <= neg_next;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        lo_reg   <= lo_next;
        r_reg    <= r_next;
        qacc_reg <= qacc_next;
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

### rtl/sws_cfg.sv
// Configuration register file: tick rate behind an APB-style port.
module sws_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sws_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [31:0]                   tick_rate
);
    import sws_pkg::*;

    logic [31:0] tick_rate_reg, tick_rate_next;
    logic        wr_en;
    logic        hit;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign hit    = (paddr[PADDR_W-1] == REG_TICK_RATE);

    // Decode the write transaction
    always_comb
    begin
        tick_rate_next = tick_rate_reg;
        if (wr_en && hit)
        begin
            tick_rate_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg <= TICK_RATE_RST;
        end
        else
        begin
            tick_rate_reg <= tick_rate_next;
        end
    end

    assign prdata    = hit ? tick_rate_reg : 32'd0;
    assign tick_rate = tick_rate_reg;

endmodule

### tb/sv/windowed_sample_statistics_core_tb.sv
// Self-checking testbench for the windowed sample statistics core.
module windowed_sample_statistics_core_tb;
    import sws_pkg::*;

    typedef struct {
        logic [1:0]         act;
        logic signed [31:0] val;
        logic [31:0]        tm;
        logic [3:0]         sel;
        logic [7:0]         age;
    } stat_req_t;

    typedef struct {
        logic signed [63:0] res;
        logic [8:0]         cnt;
    } stat_resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] action = ACT_QUERY;
    logic signed [31:0] sample_value = '0;
    logic [31:0] sample_time = '0;
    logic [3:0] stat_select = STAT_MAX;
    logic [7:0] entry_age = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [63:0] result_value;
    logic [8:0] filled_count;

    windowed_sample_statistics_core dut (.*);

    always #5 clk = ~clk;

    // Predictor state
    logic [31:0]        ticks_per_sec = TICK_RATE_RST;
    logic signed [31:0] win_value [WINDOW_DEPTH];
    logic [31:0]        win_begin [WINDOW_DEPTH];
    logic [31:0]        win_end [WINDOW_DEPTH];
    logic signed [32:0] win_dur [WINDOW_DEPTH];
    int                 win_count;
    int                 cur_slot;
    int                 open_slot;
    logic signed [31:0] newest_value;

    stat_req_t  pending_reqs[$];
    stat_resp_t expected_resps[$];
    int  errors = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_queries = 0;
    logic quiet = 1'b0;
    logic hold_go = 1'b0;
    int  hold_cycles = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    logic in_accepted = 1'b0;
    logic [31:0] clock_ticks = 0;

    function automatic void empty_window();
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            win_value[k] = '0;
            win_begin[k] = '0;
            win_end[k] = '0;
            win_dur[k] = '0;
        end
        win_count = 0;
        cur_slot = WINDOW_DEPTH - 1;
        open_slot = 0;
        newest_value = '0;
    endfunction

    // a * b / d truncated toward zero, saturated to 64-bit signed
    function automatic logic signed [63:0] scale_div(longint a, logic [31:0] b, longint d);
        logic neg;
        logic [63:0] ua;
        logic [63:0] ud;
        logic [127:0] q;
        neg = (a < 0) ^ (d < 0);
        ua = (a < 0) ? -a : a;
        ud = (d < 0) ? -d : d;
        q = ({64'd0, ua} * {96'd0, b}) / {64'd0, ud};
        if (neg)
            return (q >= 128'h8000_0000_0000_0000) ? S64_MIN : -$signed(q[63:0]);
        return (q > 128'h7FFF_FFFF_FFFF_FFFF) ? S64_MAX : $signed(q[63:0]);
    endfunction

    function automatic logic signed [63:0] slot_rate(int s);
        if (win_dur[s] == 0) return 0;
        return scale_div(longint'(win_value[s]), ticks_per_sec, longint'(win_dur[s]));
    endfunction

    function automatic logic signed [63:0] window_stat(logic [3:0] sel, logic [7:0] age);
        int n;
        int cnt;
        int s;
        longint vsum;
        longint dsum;
        longint mx;
        longint mn;
        longint dmin;
        longint rmax;
        longint rmin;
        longint r;
        logic have_d;
        n = (win_count < WINDOW_DEPTH) ? win_count : WINDOW_DEPTH;
        cnt = 0;
        vsum = 0;
        dsum = 0;
        mx = newest_value;
        mn = newest_value;
        dmin = 0;
        have_d = 1'b0;
        // prime rate extremes from slot 0 or slot 1
        if (open_slot != 0 && win_dur[0] != 0) rmax = slot_rate(0);
        else if (win_count > 0 && win_dur[1] != 0) rmax = slot_rate(1);
        else rmax = 0;
        rmin = rmax;
        for (int i = 0; i < n; i++) begin
            if (i != open_slot) begin
                cnt++;
                vsum += win_value[i];
                dsum += win_dur[i];
                if (win_value[i] > mx) mx = win_value[i];
                if (win_value[i] < mn) mn = win_value[i];
                if (!have_d || win_dur[i] < dmin) begin
                    dmin = win_dur[i];
                    have_d = 1'b1;
                end
                if (win_dur[i] > 0) begin
                    r = slot_rate(i);
                    if (r > rmax) rmax = r;
                    if (r < rmin) rmin = r;
                end
            end
        end
        s = (cur_slot + WINDOW_DEPTH - (age % WINDOW_DEPTH)) % WINDOW_DEPTH;
        case (sel)
            STAT_MAX:       return mx;
            STAT_MIN:       return mn;
            STAT_SUM:       return vsum;
            STAT_MEAN:      return cnt ? vsum / cnt : 0;
            STAT_SUMDUR:    return dsum;
            STAT_MEANDUR:   return cnt ? dsum / cnt : 0;
            STAT_MINDUR:    return dmin;
            STAT_MEANRATE:  return dsum > 0 ? scale_div(vsum, ticks_per_sec, dsum) : 0;
            STAT_MAXRATE:   return rmax;
            STAT_MINRATE:   return rmin;
            STAT_PREV:      return s == open_slot ? 0 : longint'(win_value[s]);
            STAT_PREVRATE:  return s == open_slot ? 0 : slot_rate(s);
            STAT_PREVBEGIN: return s == open_slot ? 0 : longint'({1'b0, win_begin[s]});
            STAT_PREVEND:   return s == open_slot ? 0 : longint'({1'b0, win_end[s]});
            default:        return 0;
        endcase
    endfunction

    // Advance the window by one transaction and return its result
    function automatic stat_resp_t apply_request(stat_req_t rq);
        stat_resp_t rs;
        rs.res = 0;
        case (rq.act)
            ACT_ADD: begin
                if (win_count < WINDOW_DEPTH) win_count++;
                cur_slot = (cur_slot + 1) % WINDOW_DEPTH;
                open_slot = (open_slot + 1) % WINDOW_DEPTH;
                win_value[cur_slot] = rq.val;
                win_end[cur_slot] = rq.tm;
                win_dur[cur_slot] = $signed({1'b0, rq.tm}) - $signed({1'b0, win_begin[cur_slot]});
                newest_value = rq.val;
                win_begin[open_slot] = rq.tm;
                win_end[open_slot] = rq.tm;
                win_dur[open_slot] = '0;
            end
            ACT_START: win_begin[open_slot] = rq.tm;
            ACT_QUERY: rs.res = window_stat(rq.sel, rq.age);
            default:   empty_window();
        endcase
        rs.cnt = win_count[8:0];
        return rs;
    endfunction

    // Record accepted input transactions
    always @(posedge clk) begin
        stat_req_t rq;
        rq.act = action;
        rq.val = sample_value;
        rq.tm = sample_time;
        rq.sel = stat_select;
        rq.age = entry_age;
        in_accepted <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall) begin
            expected_resps.push_back(apply_request(rq));
            n_items++;
            if (rq.act == ACT_QUERY) n_queries++;
        end
    end

    // Check output transactions against the oldest expectation
    always @(posedge clk) begin
        stat_resp_t ex;
        if (rst_n && out_valid && !out_stall) begin
            n_results++;
            if (expected_resps.size() == 0) begin
                $display("%0t: unexpected result value=%0d count=%0d",
                         $time, result_value, filled_count);
                errors++;
            end else begin
                ex = expected_resps.pop_front();
                if (result_value !== ex.res) begin
                    $display("%0t: result_value expected %0d actual %0d",
                             $time, ex.res, result_value);
                    errors++;
                end
                if (filled_count !== ex.cnt) begin
                    $display("%0t: filled_count expected %0d actual %0d",
                             $time, ex.cnt, filled_count);
                    errors++;
                end
            end
        end
    end

    // Drive input transactions from the pending queue
    always @(negedge clk) begin
        stat_req_t rq;
        if (rst_n && (!in_valid || in_accepted)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                rq = pending_reqs.pop_front();
                in_valid <= 1'b1;
                action <= rq.act;
                sample_value <= rq.val;
                sample_time <= rq.tm;
                stat_select <= rq.sel;
                entry_age <= rq.age;
                if (!quiet && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 13);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Drive receiver stalls, including one long hold
    always @(negedge clk) begin
        if (hold_go && hold_cycles < 400) begin
            hold_cycles++;
            out_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(1, 13) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic push_req(logic [1:0] act, logic signed [31:0] val, logic [31:0] tm,
                            logic [3:0] sel, logic [7:0] age);
        stat_req_t rq;
        rq.act = act;
        rq.val = val;
        rq.tm = tm;
        rq.sel = sel;
        rq.age = age;
        pending_reqs.push_back(rq);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_tick_rate(logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({REG_TICK_RATE, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        ticks_per_sec = value;
    endtask

    // Random transaction: mostly adds with rising time and queries
    task automatic push_random();
        int r;
        int x;
        logic signed [31:0] v;
        logic [31:0] t;
        r = $urandom_range(0, 99);
        v = $urandom;
        if ($urandom_range(0, 9) == 0)
            v = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        clock_ticks += $urandom_range(0, 5000);
        t = ($urandom_range(0, 19) == 0) ? 32'($urandom) : clock_ticks;
        if (r < 46) begin
            push_req(ACT_ADD, v, t, 4'($urandom), 8'($urandom));
        end else if (r < 56) begin
            // start occasionally lies after the next add time
            push_req(ACT_START, v, t + $urandom_range(0, 8000), 4'($urandom), 8'($urandom));
        end else if (r < 98) begin
            x = $urandom_range(0, 99);
            if (x < 6) x = STAT_MAXRATE + (x & 1);
            else begin
                x = $urandom_range(0, 13);
                if (x >= STAT_MAXRATE) x += 2;
            end
            push_req(ACT_QUERY, v, t, 4'(x), 8'($urandom));
        end else begin
            push_req(ACT_CLEAR, v, t, 4'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        logic [31:0] rates [5];
        empty_window();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty window, extreme values, negative durations, all selects
        push_req(ACT_QUERY, 0, 0, STAT_MAX, 0);
        push_req(ACT_QUERY, 0, 0, STAT_MAXRATE, 0);
        push_req(ACT_QUERY, 0, 0, STAT_PREV, 0);
        push_req(ACT_ADD, 32'sh7FFF_FFFF, 32'd100, STAT_MAX, 0);
        push_req(ACT_ADD, 32'sh8000_0000, 32'd50, STAT_MAX, 0);
        push_req(ACT_START, 0, 32'd1000, STAT_MAX, 0);
        push_req(ACT_ADD, 32'sd1, 32'd400, STAT_MAX, 0);
        push_req(ACT_ADD, -32'sd1, 32'hFFFF_FFFF, STAT_MAX, 0);
        for (int k = 0; k < 16; k++)
            push_req(ACT_QUERY, 0, 0, 4'(k), 8'(k * 17));
        push_req(ACT_QUERY, 0, 0, STAT_PREVEND, 8'd255);
        push_req(ACT_CLEAR, 0, 0, STAT_MAX, 0);
        push_req(ACT_QUERY, 0, 0, STAT_MINDUR, 0);
        wait_idle();

        // Random phases over several tick rates, extremes among them
        rates[0] = TICK_RATE_RST;
        rates[1] = 32'd1;
        rates[2] = 32'hFFFF_FFFF;
        rates[3] = $urandom;
        rates[4] = $urandom_range(1, 100000);
        for (int p = 0; p < 5; p++) begin
            if (p > 0) write_tick_rate(rates[p]);
            if (p == 4) quiet = 1'b1;
            for (int k = 0; k < 186; k++) begin
                if (p == 1 && k == 60) begin
                    // fill the block with cheap adds behind a long output hold
                    hold_go = 1'b1;
                    for (int j = 0; j < 20; j++) begin
                        clock_ticks += 7;
                        push_req(ACT_ADD, 32'($urandom), clock_ticks, 0, 0);
                    end
                end
                push_random();
            end
            wait_idle();
        end

        repeat (50) @(posedge clk);
        $display("Covered %0d transactions (%0d queries), %0d results checked, %0d errors",
                 n_items, n_queries, n_results, errors);
        $display("Tick rates exercised: reset value, 1, all ones and two random values");
        if (errors == 0 && expected_resps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial begin
        #100000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
